// ----- src/vdcm_pkg.sv -----
// Package for the vector direction color map: widths, fixed-point constants,
// the arctangent table and the shared sideband type. No dependencies.
package vdcm_pkg;

    localparam int COMPONENT_BITS = 16;
    localparam int CORDIC_STEPS   = 16;
    localparam int PRESCALE       = 40 - COMPONENT_BITS;
    localparam int W_DATA         = 44;
    localparam int W_ANG          = 26;
    localparam int W_STEP         = 5;
    localparam int N_STAGES       = 2 * CORDIC_STEPS + 6;

    localparam logic signed [W_ANG-1:0] DEG90  = W_ANG'(90 * 65536);
    localparam logic signed [W_ANG-1:0] DEG120 = W_ANG'(120 * 65536);
    localparam logic signed [W_ANG-1:0] DEG240 = W_ANG'(240 * 65536);
    localparam logic signed [W_ANG-1:0] DEG360 = W_ANG'(360 * 65536);
    localparam logic [23:0]             DEG255 = 24'(255 * 65536);
    localparam logic [15:0]             INV_GAIN = 16'd39797;
    localparam logic [23:0]             INV90    = 24'd11930465;

    typedef struct packed {
        logic                    mask;
        logic                    zero;
        logic signed [W_DATA-1:0] z;
        logic signed [W_ANG-1:0]  trend;
    } t_side;

    typedef enum logic [1:0] {
        SEG_RG = 2'd0,
        SEG_GB = 2'd1,
        SEG_BR = 2'd2
    } t_seg;

    function automatic logic signed [W_ANG-1:0] atan_q16(input logic [W_STEP-1:0] i);
        logic signed [W_ANG-1:0] a;
        a = '0;
        case (i)
            5'd0:  a = W_ANG'(2949120);
            5'd1:  a = W_ANG'(1740967);
            5'd2:  a = W_ANG'(919879);
            5'd3:  a = W_ANG'(466945);
            5'd4:  a = W_ANG'(234379);
            5'd5:  a = W_ANG'(117304);
            5'd6:  a = W_ANG'(58666);
            5'd7:  a = W_ANG'(29335);
            5'd8:  a = W_ANG'(14668);
            5'd9:  a = W_ANG'(7334);
            5'd10: a = W_ANG'(3667);
            5'd11: a = W_ANG'(1833);
            5'd12: a = W_ANG'(917);
            5'd13: a = W_ANG'(458);
            5'd14: a = W_ANG'(229);
            5'd15: a = W_ANG'(115);
            5'd16: a = W_ANG'(57);
            5'd17: a = W_ANG'(29);
            5'd18: a = W_ANG'(14);
            5'd19: a = W_ANG'(7);
            5'd20: a = W_ANG'(4);
            5'd21: a = W_ANG'(2);
            5'd22: a = W_ANG'(1);
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// ----- src/vdcm_if.sv -----
// Valid/ready channel interfaces for vector input and color output.
// Depends on vdcm_pkg.
interface vdcm_in_if;
    import vdcm_pkg::*;
    logic                             valid;
    logic                             ready;
    logic                             mask_on;
    logic signed [COMPONENT_BITS-1:0] vec_x;
    logic signed [COMPONENT_BITS-1:0] vec_y;
    logic signed [COMPONENT_BITS-1:0] vec_z;
    modport source (output valid, mask_on, vec_x, vec_y, vec_z, input ready);
    modport sink   (input valid, mask_on, vec_x, vec_y, vec_z, output ready);
    modport monitor (input valid, ready, mask_on, vec_x, vec_y, vec_z);
endinterface

interface vdcm_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
    modport monitor (input valid, ready, red, green, blue);
endinterface

// ----- src/vector_direction_color_map.sv -----
// Top level of the vector direction color map: input conditioning, two
// CORDIC vectoring pipelines, length scaling and the color stages.
// Depends on vdcm_pkg, vdcm_if, vdcm_cordic_stage and vdcm_color.
//
//   channel  direction  fields
//   i_in     in         mask_on, vec_x, vec_y, vec_z
//   o_out    out        red, green, blue
//
// One transaction is accepted per cycle while the output is not stalled.
// The rate is set by the fully pipelined CORDIC steps and color stages.
// Reset clears only the stage valid bits.
// A stalled output holds the whole pipeline; nothing is lost or repeated.
module vector_direction_color_map (
    input  logic        i_clk,
    input  logic        i_rst_n,
    vdcm_in_if.sink     i_in,
    vdcm_out_if.source  o_out
);
    import vdcm_pkg::*;

    localparam int S = CORDIC_STEPS;

    logic                en;
    logic [N_STAGES-1:0] r_vld;

    logic signed [W_DATA-1:0] xs, ys, zs, cx, cy;
    logic signed [W_ANG-1:0]  ang0;
    t_side                    n_side;

    logic signed [W_DATA-1:0] r_p0_x, r_p0_y;
    logic signed [W_ANG-1:0]  r_p0_ang;
    t_side                    r_p0_side;

    logic signed [W_DATA-1:0] c1_x [S+1];
    logic signed [W_DATA-1:0] c1_y [S+1];
    logic signed [W_ANG-1:0]  c1_a [S+1];
    t_side                    c1_s [S+1];
    logic signed [W_DATA-1:0] c2_x [S+1];
    logic signed [W_DATA-1:0] c2_y [S+1];
    logic signed [W_ANG-1:0]  c2_a [S+1];
    t_side                    c2_s [S+1];

    logic signed [59:0]       rho_m;
    logic signed [W_ANG-1:0]  tr;
    t_side                    n_rho_side;
    logic signed [W_DATA-1:0] r_rho;
    t_side                    r_rho_side;

    assign en         = !r_vld[N_STAGES-1] || o_out.ready;
    assign i_in.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[N_STAGES-2:0], i_in.valid};
        end
    end

    always_comb begin
        xs = W_DATA'(i_in.vec_x) <<< PRESCALE;
        ys = W_DATA'(i_in.vec_y) <<< PRESCALE;
        zs = W_DATA'(i_in.vec_z) <<< PRESCALE;
        if (zs < 0) begin
            xs = -xs;
            ys = -ys;
            zs = -zs;
        end
        cx   = xs;
        cy   = ys;
        ang0 = '0;
        if (xs < 0) begin
            if (ys >= 0) begin
                cx   = ys;
                cy   = -xs;
                ang0 = DEG90;
            end else begin
                cx   = -ys;
                cy   = xs;
                ang0 = -DEG90;
            end
        end
        n_side.mask  = i_in.mask_on;
        n_side.zero  = (i_in.vec_x == 0) && (i_in.vec_y == 0) && (i_in.vec_z == 0);
        n_side.z     = zs;
        n_side.trend = '0;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p0_x    <= cx;
            r_p0_y    <= cy;
            r_p0_ang  <= ang0;
            r_p0_side <= n_side;
        end
    end

    assign c1_x[0] = r_p0_x;
    assign c1_y[0] = r_p0_y;
    assign c1_a[0] = r_p0_ang;
    assign c1_s[0] = r_p0_side;

    for (genvar i = 0; i < S; i++) begin : g_pass1
        vdcm_cordic_stage u_stage (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_step (W_STEP'(i)),
            .i_x    (c1_x[i]),
            .i_y    (c1_y[i]),
            .i_ang  (c1_a[i]),
            .i_side (c1_s[i]),
            .o_x    (c1_x[i+1]),
            .o_y    (c1_y[i+1]),
            .o_ang  (c1_a[i+1]),
            .o_side (c1_s[i+1])
        );
    end

    always_comb begin
        rho_m = 60'(c1_x[S]) * 60'(signed'({1'b0, INV_GAIN}));
        tr    = c1_a[S];
        if (tr < 0) begin
            tr = tr + DEG360;
        end
        if (tr >= DEG360) begin
            tr = tr - DEG360;
        end
        if (tr < 0) begin
            tr = '0;
        end
        n_rho_side       = c1_s[S];
        n_rho_side.trend = tr;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rho      <= (rho_m < 0) ? '0 : W_DATA'(rho_m >>> 16);
            r_rho_side <= n_rho_side;
        end
    end

    assign c2_x[0] = r_rho_side.z;
    assign c2_y[0] = r_rho;
    assign c2_a[0] = '0;
    assign c2_s[0] = r_rho_side;

    for (genvar i = 0; i < S; i++) begin : g_pass2
        vdcm_cordic_stage u_stage (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_step (W_STEP'(i)),
            .i_x    (c2_x[i]),
            .i_y    (c2_y[i]),
            .i_ang  (c2_a[i]),
            .i_side (c2_s[i]),
            .o_x    (c2_x[i+1]),
            .o_y    (c2_y[i+1]),
            .o_ang  (c2_a[i+1]),
            .o_side (c2_s[i+1])
        );
    end

    vdcm_color u_color (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_trend  (c2_s[S].trend),
        .i_plunge (c2_a[S]),
        .i_mask   (c2_s[S].mask),
        .i_zero   (c2_s[S].zero),
        .o_red    (o_out.red),
        .o_green  (o_out.green),
        .o_blue   (o_out.blue)
    );

    assign o_out.valid = r_vld[N_STAGES-1];
endmodule

// ----- src/vdcm_cordic_stage.sv -----
// One registered CORDIC vectoring step with sideband.
// Depends on vdcm_pkg.
module vdcm_cordic_stage (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic [vdcm_pkg::W_STEP-1:0]       i_step,
    input  logic signed [vdcm_pkg::W_DATA-1:0] i_x,
    input  logic signed [vdcm_pkg::W_DATA-1:0] i_y,
    input  logic signed [vdcm_pkg::W_ANG-1:0]  i_ang,
    input  vdcm_pkg::t_side                   i_side,
    output logic signed [vdcm_pkg::W_DATA-1:0] o_x,
    output logic signed [vdcm_pkg::W_DATA-1:0] o_y,
    output logic signed [vdcm_pkg::W_ANG-1:0]  o_ang,
    output vdcm_pkg::t_side                   o_side
);
    import vdcm_pkg::*;

    logic signed [W_DATA-1:0] dx, dy, n_x, n_y;
    logic signed [W_ANG-1:0]  n_ang, a;
    logic signed [W_DATA-1:0] r_x, r_y;
    logic signed [W_ANG-1:0]  r_ang;
    t_side                    r_side;

    always_comb begin
        dx = i_y >>> i_step;
        dy = i_x >>> i_step;
        a  = atan_q16(i_step);
        if (i_y > 0) begin
            n_x   = i_x + dx;
            n_y   = i_y - dy;
            n_ang = i_ang + a;
        end else begin
            n_x   = i_x - dx;
            n_y   = i_y + dy;
            n_ang = i_ang - a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_ang  <= n_ang;
            r_side <= i_side;
        end
    end

    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_ang  = r_ang;
    assign o_side = r_side;
endmodule

// ----- src/vdcm_color.sv -----
// Four-stage hue and white blend from trend and plunge angles.
// Depends on vdcm_pkg.
module vdcm_color (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [vdcm_pkg::W_ANG-1:0]  i_trend,
    input  logic signed [vdcm_pkg::W_ANG-1:0]  i_plunge,
    input  logic                              i_mask,
    input  logic                              i_zero,
    output logic [7:0]                        o_red,
    output logic [7:0]                        o_green,
    output logic [7:0]                        o_blue
);
    import vdcm_pkg::*;

    logic signed [W_ANG-1:0] p;
    logic [22:0]             n_wn;
    t_seg                    seg;
    logic [22:0]             t;
    logic [27:0]             rise_m, fall_m;
    logic [23:0]             n_ch [3];

    logic [23:0] r_a_ch [3];
    logic [46:0] r_a_prod;
    logic [1:0]  r_a_f;
    logic [23:0] r_b_ch [3];
    logic [16:0] r_b_w;
    logic [1:0]  r_b_f;
    logic [23:0] r_c_ch [3];
    logic [40:0] r_c_prod [3];
    logic [1:0]  r_c_f;
    logic [7:0]  r_out [3];

    always_comb begin
        if (i_plunge < 0) begin
            p = '0;
        end else if (i_plunge > DEG90) begin
            p = DEG90;
        end else begin
            p = i_plunge;
        end
        n_wn = 23'(DEG90 - p);
        if (i_trend <= DEG120) begin
            seg = SEG_RG;
            t   = 23'(i_trend);
        end else if (i_trend <= DEG240) begin
            seg = SEG_GB;
            t   = 23'(i_trend - DEG120);
        end else begin
            seg = SEG_BR;
            t   = 23'(i_trend - DEG240);
        end
        rise_m = 28'(t) * 28'd17;
        fall_m = 28'(23'(DEG120) - t) * 28'd17;
        n_ch[0] = '0;
        n_ch[1] = '0;
        n_ch[2] = '0;
        unique case (seg)
            SEG_RG: begin
                n_ch[0] = rise_m[26:3] == 0 ? fall_m[26:3] : fall_m[26:3];
                n_ch[1] = rise_m[26:3];
            end
            SEG_GB: begin
                n_ch[1] = fall_m[26:3];
                n_ch[2] = rise_m[26:3];
            end
            SEG_BR: begin
                n_ch[2] = fall_m[26:3];
                n_ch[0] = rise_m[26:3];
            end
            default: begin
                n_ch[0] = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_ch   <= n_ch;
            r_a_prod <= 47'(n_wn) * 47'(INV90);
            r_a_f    <= {i_mask, i_zero};
            r_b_ch   <= r_a_ch;
            r_b_w    <= r_a_prod[46:30];
            r_b_f    <= r_a_f;
            r_c_ch   <= r_b_ch;
            for (int k = 0; k < 3; k++) begin
                r_c_prod[k] <= 41'(DEG255 - r_b_ch[k]) * 41'(r_b_w);
            end
            r_c_f    <= r_b_f;
            for (int k = 0; k < 3; k++) begin
                logic [24:0] s;
                s = 25'(r_c_ch[k]) + 25'(r_c_prod[k] >> 16);
                if (!r_c_f[1]) begin
                    r_out[k] <= '0;
                end else if (r_c_f[0]) begin
                    r_out[k] <= (k == 0) ? 8'd255 : 8'd0;
                end else if (s[24]) begin
                    r_out[k] <= 8'd255;
                end else begin
                    r_out[k] <= s[23:16];
                end
            end
        end
    end

    assign o_red   = r_out[0];
    assign o_green = r_out[1];
    assign o_blue  = r_out[2];
endmodule

// ----- src/vdcm_checker.sv -----
// Port-level assertions for the vector direction color map and their bind.
// Depends on vdcm_if and vector_direction_color_map.
module vdcm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    vdcm_in_if.sink    i_in,
    vdcm_out_if.source o_out
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid)
        else $error("Output transaction dropped while stalled.");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("Output valid after reset.");

    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.ready |-> i_in.ready)
        else $error("Input stalled while output is ready.");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out.valid |-> i_in.ready)
        else $error("Input stalled with empty output stage.");
endmodule

bind vector_direction_color_map vdcm_checker u_vdcm_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_in    (i_in),
    .o_out   (o_out)
);

// ----- test/tb_color_scoreboard.sv -----
// Scoreboard class for the vector direction color map testbench: predicts the
// color of each accepted vector and checks the output transactions. Depends on vdcm_pkg.
class color_scoreboard;
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    t_rgb pending_colors[$];
    int   fail_count;

    function new();
        fail_count = 0;
    endfunction

    static function longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    static function longint atan_step(int i);
        longint tbl[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
            29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};
        return tbl[i];
    endfunction

    static function longint rotate_to_axis(inout longint px, inout longint py, input longint a0);
        longint x, y, ang, dx, dy;
        x = px;
        y = py;
        ang = a0;
        for (int i = 0; i < vdcm_pkg::CORDIC_STEPS && i < 24; i++) begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (y > 0) begin
                x += dx;
                y -= dy;
                ang += atan_step(i);
            end else begin
                x -= dx;
                y += dy;
                ang -= atan_step(i);
            end
        end
        px = x;
        py = y;
        return ang;
    endfunction

    static function t_rgb direction_color(logic m, shortint vx, shortint vy, shortint vz);
        longint x, y, z, cx, cy, a0, trend, plunge, rho, w, t, c, v;
        longint ch[3];
        int seg;
        t_rgb r;
        x = vx;
        y = vy;
        z = vz;
        r = '0;
        if (!m) return r;
        if (x == 0 && y == 0 && z == 0) begin
            r.red = 8'd255;
            return r;
        end
        if (z < 0) begin
            x = -x;
            y = -y;
            z = -z;
        end
        x = x <<< vdcm_pkg::PRESCALE;
        y = y <<< vdcm_pkg::PRESCALE;
        z = z <<< vdcm_pkg::PRESCALE;
        cx = x;
        cy = y;
        a0 = 0;
        if (x < 0) begin
            if (y >= 0) begin
                cx = y;
                cy = -x;
                a0 = 90 * 65536;
            end else begin
                cx = -y;
                cy = x;
                a0 = -90 * 65536;
            end
        end
        trend = rotate_to_axis(cx, cy, a0);
        if (trend < 0) trend += 360 * 65536;
        if (trend >= 360 * 65536) trend -= 360 * 65536;
        if (trend < 0) trend = 0;
        rho = (cx * 39797) >>> 16;
        if (rho < 0) rho = 0;
        cx = z;
        cy = rho;
        plunge = rotate_to_axis(cx, cy, 0);
        if (plunge < 0) plunge = 0;
        if (plunge > 90 * 65536) plunge = 90 * 65536;
        seg = (trend <= 120 * 65536) ? 0 : (trend <= 240 * 65536) ? 1 : 2;
        t = trend - longint'(120 * 65536) * seg;
        ch[seg] = (255 * (120 * 65536 - t)) / 120;
        ch[(seg + 1) % 3] = (255 * t) / 120;
        ch[(seg + 2) % 3] = 0;
        w = (90 * 65536 - plunge) / 90;
        for (int k = 0; k < 3; k++) begin
            c = ch[k];
            c += ((255 * 65536 - c) * w) >>> 16;
            v = c >>> 16;
            if (v > 255) v = 255;
            if (v < 0) v = 0;
            ch[k] = v;
        end
        r.red = ch[0][7:0];
        r.green = ch[1][7:0];
        r.blue = ch[2][7:0];
        return r;
    endfunction

    function void note_vector(logic m, shortint vx, shortint vy, shortint vz);
        pending_colors.push_back(direction_color(m, vx, vy, vz));
    endfunction

    function void check_color(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        t_rgb e;
        if (pending_colors.size() == 0) begin
            $error("Output transaction with no expected color.");
            fail_count++;
            return;
        end
        e = pending_colors.pop_front();
        if (r !== e.red) begin
            $error("red: expected %0d, actual %0d", e.red, r);
            fail_count++;
        end
        if (g !== e.green) begin
            $error("green: expected %0d, actual %0d", e.green, g);
            fail_count++;
        end
        if (b !== e.blue) begin
            $error("blue: expected %0d, actual %0d", e.blue, b);
            fail_count++;
        end
    endfunction
endclass

// ----- test/tb_top.sv -----
// Top-level testbench for vector_direction_color_map: directed and random
// vectors with random idling on both sides. Depends on vdcm_pkg, vdcm_if, the scoreboard.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   send_idle = 36;
    int   recv_idle = 65;
    bit   hold_off = 1'b0;
    bit   stim_done = 1'b0;
    color_scoreboard colors = new();

    vdcm_in_if  in_ch();
    vdcm_out_if out_ch();

    vector_direction_color_map dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.mask_on = 1'b0;
        in_ch.vec_x = '0;
        in_ch.vec_y = '0;
        in_ch.vec_z = '0;
        out_ch.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            colors.note_vector(in_ch.mask_on, in_ch.vec_x, in_ch.vec_y, in_ch.vec_z);
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            colors.check_color(out_ch.red, out_ch.green, out_ch.blue);
        end
    end

    always @(negedge i_clk) begin
        out_ch.ready <= i_rst_n && !hold_off && ($urandom_range(99) >= recv_idle);
    end

    task automatic send_vector(logic m, logic [15:0] x, logic [15:0] y, logic [15:0] z);
        while ($urandom_range(99) < send_idle) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.mask_on <= m;
        in_ch.vec_x <= x;
        in_ch.vec_y <= y;
        in_ch.vec_z <= z;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    function automatic logic [15:0] random_component();
        case ($urandom_range(5))
            0: return 16'(int'($urandom_range(8)) - 4);
            1: return 16'h8000;
            2: return 16'h7fff;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_random(int n);
        logic [15:0] x, y, z;
        for (int i = 0; i < n; i++) begin
            x = random_component();
            y = random_component();
            z = random_component();
            if ($urandom_range(9) == 0) z = '0;
            if ($urandom_range(19) == 0) begin
                x = '0;
                y = '0;
            end
            send_vector($urandom_range(9) != 0, x, y, z);
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        send_vector(1'b0, 16'h7fff, 16'h1234, 16'h8000);
        send_vector(1'b1, 16'h0000, 16'h0000, 16'h0000);
        send_vector(1'b1, 16'h7fff, 16'h0000, 16'h0000);
        send_vector(1'b1, 16'h8000, 16'h0000, 16'h0000);
        send_vector(1'b1, 16'h0000, 16'h7fff, 16'h0000);
        send_vector(1'b1, 16'h0000, 16'h8000, 16'h0000);
        send_vector(1'b1, 16'h0000, 16'h0000, 16'h7fff);
        send_vector(1'b1, 16'h0000, 16'h0000, 16'h8000);
        send_vector(1'b1, 16'h7fff, 16'hffff, 16'h0000);
        send_vector(1'b1, 16'h8000, 16'h8000, 16'h8000);
        send_vector(1'b1, 16'h7fff, 16'h7fff, 16'h7fff);
        send_vector(1'b1, 16'hc000, 16'h6ed9, 16'h0000);
        send_vector(1'b1, 16'hc000, 16'h9127, 16'h0000);
        send_vector(1'b1, 16'h1000, 16'h2000, 16'hd000);
        send_vector(1'b1, 16'h0001, 16'h0000, 16'h0000);
        send_vector(1'b1, 16'hffff, 16'hffff, 16'hffff);
        send_random(400);
        hold_off = 1'b1;
        fork
            begin
                repeat (150) @(negedge i_clk);
                hold_off = 1'b0;
            end
            send_random(80);
        join
        send_idle = 65;
        recv_idle = 36;
        send_random(400);
        send_idle = 0;
        recv_idle = 0;
        send_random(370);
        in_ch.valid <= 1'b0;
        while (colors.pending_colors.size() != 0) @(negedge i_clk);
        repeat (2 * vdcm_pkg::N_STAGES) @(negedge i_clk);
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done);
        if (colors.fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end
endmodule

// ----- vector_direction_color_map.f -----
src/vdcm_pkg.sv
src/vdcm_if.sv
src/vdcm_cordic_stage.sv
src/vdcm_color.sv
src/vector_direction_color_map.sv
src/vdcm_checker.sv
test/tb_color_scoreboard.sv
test/tb_top.sv
